// ===== rtl/cist_pkg.sv =====
package cist_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic        ext;
      logic [28:0] id;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [31:0] frames;
      logic [31:0] time_ms;
      logic [3:0]  len;
      logic [63:0] bytes;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_WRITE  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_READ  = 1'b1;

endpackage

// ===== rtl/can_id_survey_table_top.sv =====
// Channel   Ports   Direction  Beat
// request   req_*   in         one frame to record or one entry to read
// response  rsp_*   out        one result per request beat
//
// A frame beat scans the table one entry per cycle through the registered
// memory read port. A new beat is taken when the block is idle, even while
// the last result still waits in the output register.
// Synchronous reset clears the used count, the overflow flag and the control;
// table contents are left as they are.
module can_id_survey_table_top
   import cist_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [28:0] req_frame_id,
   input  logic        req_is_extended,
   input  logic [3:0]  req_length_code,
   input  logic [63:0] req_payload,
   input  logic [31:0] req_rx_time_ms,
   input  logic [6:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_matched,
   output logic        rsp_added,
   output logic        rsp_overflowed,
   output logic [7:0]  rsp_entries_used,
   output logic        rsp_read_valid,
   output logic [28:0] rsp_read_id,
   output logic        rsp_read_extended,
   output logic [31:0] rsp_read_count,
   output logic [31:0] rsp_read_time_ms,
   output logic [3:0]  rsp_read_length,
   output logic [63:0] rsp_read_payload
);

   entry_type mem [TABLE_DEPTH];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             full_ff, full_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             hit_ff, hit_in;
   logic             add_ff, add_in;
   logic [31:0]      count_ff, count_in;

   logic             kind_ff;
   key_type          key_ff;
   logic [3:0]       len_ff;
   logic [63:0]      bytes_ff;
   logic [31:0]      time_ff;
   logic [6:0]       index_ff;

   entry_type        rdata_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   entry_type        wr_data;
   logic             read_hit;
   logic             accept;
   logic             out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_matched_ff, rsp_added_ff, rsp_overflowed_ff, rsp_read_valid_ff;
   logic [7:0]  rsp_entries_used_ff;
   entry_type   rsp_entry_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign read_hit  = (CNT_W + 7)'(index_ff) < (CNT_W + 7)'(used_ff);

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      full_in     = full_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      wr_idx_in   = wr_idx_ff;
      hit_in      = hit_ff;
      add_in      = add_ff;
      count_in    = count_ff;
      rd_en       = 1'b0;
      rd_addr     = scan_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in  = 1'b0;
               add_in  = 1'b0;
               scan_in = '0;
               if (req_kind == KIND_READ) begin
                  state_in = ST_READ;
               end else if (used_ff == '0) begin
                  add_in    = 1'b1;
                  wr_idx_in = '0;
                  count_in  = 32'd1;
                  state_in  = ST_WRITE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff < used_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end
            if (pend_ff) begin
               if (rdata_ff.key == key_ff) begin
                  hit_in    = 1'b1;
                  wr_idx_in = pend_idx_ff;
                  count_in  = rdata_ff.frames + 32'd1;
                  state_in  = ST_WRITE;
               end else if (CNT_W'(pend_idx_ff) + 1'b1 == used_ff) begin
                  if (used_ff < CNT_W'(TABLE_DEPTH)) begin
                     add_in    = 1'b1;
                     wr_idx_in = used_ff[IDX_W-1:0];
                     count_in  = 32'd1;
                     state_in  = ST_WRITE;
                  end else begin
                     full_in  = 1'b1;
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (add_ff) begin
               used_in = used_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = IDX_W'(index_ff);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wr_data.key     = key_ff;
      wr_data.frames  = count_ff;
      wr_data.time_ms = time_ff;
      wr_data.len     = len_ff;
      wr_data.bytes   = bytes_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         full_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         full_ff      <= full_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      wr_idx_ff   <= wr_idx_in;
      hit_ff      <= hit_in;
      add_ff      <= add_in;
      count_ff    <= count_in;
      if (accept) begin
         kind_ff  <= req_kind;
         key_ff   <= '{ext: req_is_extended, id: req_frame_id};
         len_ff   <= req_length_code;
         bytes_ff <= req_payload;
         time_ff  <= req_rx_time_ms;
         index_ff <= req_entry_index;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && out_free) begin
         rsp_overflowed_ff   <= full_ff;
         rsp_entries_used_ff <= 8'(used_ff);
         if (kind_ff == KIND_READ) begin
            rsp_matched_ff    <= 1'b0;
            rsp_added_ff      <= 1'b0;
            rsp_read_valid_ff <= read_hit;
            rsp_entry_ff      <= read_hit ? rdata_ff : '0;
         end else begin
            rsp_matched_ff    <= hit_ff;
            rsp_added_ff      <= add_ff;
            rsp_read_valid_ff <= 1'b0;
            rsp_entry_ff      <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_added         = rsp_added_ff;
   assign rsp_overflowed    = rsp_overflowed_ff;
   assign rsp_entries_used  = rsp_entries_used_ff;
   assign rsp_read_valid    = rsp_read_valid_ff;
   assign rsp_read_id       = rsp_entry_ff.key.id;
   assign rsp_read_extended = rsp_entry_ff.key.ext;
   assign rsp_read_count    = rsp_entry_ff.frames;
   assign rsp_read_time_ms  = rsp_entry_ff.time_ms;
   assign rsp_read_length   = rsp_entry_ff.len;
   assign rsp_read_payload  = rsp_entry_ff.bytes;

endmodule

// ===== dv/can_id_survey_table_top_test.sv =====
`timescale 1ns / 1ps

module can_id_survey_table_top_test
   import cist_pkg::*;
();

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 150;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic        kind;
      logic [28:0] frame_id;
      logic        is_extended;
      logic [3:0]  length_code;
      logic [63:0] payload;
      logic [31:0] rx_time_ms;
      logic [6:0]  entry_index;
      int          gap;
   } survey_req_type;

   typedef struct {
      logic        matched;
      logic        added;
      logic        overflowed;
      logic [7:0]  entries_used;
      logic        read_valid;
      logic [28:0] read_id;
      logic        read_extended;
      logic [31:0] read_count;
      logic [31:0] read_time_ms;
      logic [3:0]  read_length;
      logic [63:0] read_payload;
   } survey_rsp_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic        req_kind          = 1'b0;
   logic [28:0] req_frame_id      = '0;
   logic        req_is_extended   = 1'b0;
   logic [3:0]  req_length_code   = '0;
   logic [63:0] req_payload       = '0;
   logic [31:0] req_rx_time_ms    = '0;
   logic [6:0]  req_entry_index   = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic        rsp_matched;
   logic        rsp_added;
   logic        rsp_overflowed;
   logic [7:0]  rsp_entries_used;
   logic        rsp_read_valid;
   logic [28:0] rsp_read_id;
   logic        rsp_read_extended;
   logic [31:0] rsp_read_count;
   logic [31:0] rsp_read_time_ms;
   logic [3:0]  rsp_read_length;
   logic [63:0] rsp_read_payload;

   survey_req_type pending_reqs[$];
   survey_rsp_type due_rsps[$];
   survey_req_type next_req;
   entry_type   shadow_tab[TABLE_DEPTH];
   int          shadow_used  = 0;
   logic        shadow_full  = 1'b0;
   int          mismatches   = 0;
   int          reqs_taken_n = 0;
   int          rsp_beats_n  = 0;
   int          cycle_n      = 0;
   int          total_reqs   = 0;
   int          req_wait     = 0;
   int          rsp_wait     = 0;
   bit          req_taken    = 1'b0;
   bit          rsp_taken    = 1'b0;
   bit          have_next    = 1'b0;

   can_id_survey_table_top dut (.*);

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   function automatic survey_req_type mk_frame(logic [28:0] id, logic ext, logic [3:0] len,
                                               logic [63:0] data, logic [31:0] stamp);
      survey_req_type r;
      r.kind        = KIND_FRAME;
      r.frame_id    = id;
      r.is_extended = ext;
      r.length_code = len;
      r.payload     = data;
      r.rx_time_ms  = stamp;
      r.entry_index = 7'($urandom_range(0, 127));
      r.gap         = $urandom_range(0, 3);
      return r;
   endfunction

   function automatic survey_req_type mk_read(logic [6:0] idx);
      survey_req_type r;
      r = mk_frame(29'($urandom), 1'($urandom), 4'($urandom), {$urandom, $urandom}, $urandom);
      r.kind        = KIND_READ;
      r.entry_index = idx;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("result beat %0d: %s expected %0h, got %0h", rsp_beats_n, name, want, got);
      end
   endtask

   // request side: each item waits its own gap, then holds until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (!have_next && pending_reqs.size() != 0) begin
            next_req  = pending_reqs.pop_front();
            have_next = 1'b1;
            req_wait  = next_req.gap;
         end
         if (have_next && req_wait == 0) begin
            req_valid       <= 1'b1;
            req_kind        <= next_req.kind;
            req_frame_id    <= next_req.frame_id;
            req_is_extended <= next_req.is_extended;
            req_length_code <= next_req.length_code;
            req_payload     <= next_req.payload;
            req_rx_time_ms  <= next_req.rx_time_ms;
            req_entry_index <= next_req.entry_index;
            have_next = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (have_next)
               req_wait--;
         end
      end
   end

   // response side: hold ready low for a drawn wait before each result
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = $urandom_range(0, 3);
      end else begin
         if (rsp_taken)
            rsp_wait = ((rsp_beats_n / 50) % 3 == 1) ? 0 : $urandom_range(0, 3);
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            if (rsp_valid)
               rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      survey_rsp_type want;
      key_type     probe;
      int          slot;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (reset) begin
         shadow_used = 0;
         shadow_full = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            reqs_taken_n++;
            want  = '{default: '0};
            probe = '{ext: req_is_extended, id: req_frame_id};
            if (req_kind == KIND_FRAME) begin
               slot = -1;
               for (int i = 0; i < shadow_used; i++)
                  if (slot < 0 && shadow_tab[i].key == probe)
                     slot = i;
               if (slot >= 0) begin
                  shadow_tab[slot].frames  = shadow_tab[slot].frames + 32'd1;
                  shadow_tab[slot].time_ms = req_rx_time_ms;
                  shadow_tab[slot].len     = req_length_code;
                  shadow_tab[slot].bytes   = req_payload;
                  want.matched = 1'b1;
               end else if (shadow_used < TABLE_DEPTH) begin
                  shadow_tab[shadow_used] = '{key: probe, frames: 32'd1,
                                              time_ms: req_rx_time_ms,
                                              len: req_length_code, bytes: req_payload};
                  shadow_used++;
                  want.added = 1'b1;
               end else begin
                  shadow_full = 1'b1;
               end
            end else if (int'(req_entry_index) < shadow_used) begin
               want.read_valid    = 1'b1;
               want.read_id       = shadow_tab[req_entry_index].key.id;
               want.read_extended = shadow_tab[req_entry_index].key.ext;
               want.read_count    = shadow_tab[req_entry_index].frames;
               want.read_time_ms  = shadow_tab[req_entry_index].time_ms;
               want.read_length   = shadow_tab[req_entry_index].len;
               want.read_payload  = shadow_tab[req_entry_index].bytes;
            end
            want.overflowed   = shadow_full;
            want.entries_used = 8'(shadow_used);
            due_rsps.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (due_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("result beat %0d arrived with nothing outstanding", rsp_beats_n);
            end else begin
               want = due_rsps.pop_front();
               check_field("matched", 64'(want.matched), 64'(rsp_matched));
               check_field("added", 64'(want.added), 64'(rsp_added));
               check_field("overflowed", 64'(want.overflowed), 64'(rsp_overflowed));
               check_field("entries_used", 64'(want.entries_used), 64'(rsp_entries_used));
               check_field("read_valid", 64'(want.read_valid), 64'(rsp_read_valid));
               check_field("read_id", 64'(want.read_id), 64'(rsp_read_id));
               check_field("read_extended", 64'(want.read_extended),
                           64'(rsp_read_extended));
               check_field("read_count", 64'(want.read_count), 64'(rsp_read_count));
               check_field("read_time_ms", 64'(want.read_time_ms), 64'(rsp_read_time_ms));
               check_field("read_length", 64'(want.read_length), 64'(rsp_read_length));
               check_field("read_payload", want.read_payload, rsp_read_payload);
            end
            rsp_beats_n++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_n++;
      if (cycle_n >= CYCLE_LIMIT) begin
         $display("can_id_survey_table_top_test: done, errors");
         $finish;
      end
   end

   initial begin
      survey_req_type item;
      key_type     gen_keys[$];
      key_type     k;
      int          gen_used;
      int          idx;
      bit          known;
      logic [3:0]  len;

      pending_reqs.push_back(mk_read(7'd0));
      pending_reqs.push_back(mk_read(7'd127));
      pending_reqs.push_back(mk_frame(29'd0, 1'b0, 4'd0, 64'd0, 32'd0));
      pending_reqs.push_back(mk_frame(29'd0, 1'b1, 4'd8, '1, '1));
      pending_reqs.push_back(mk_frame(29'h7FF, 1'b0, 4'd15, 64'h0123_4567_89AB_CDEF,
                                      32'h8000_0000));
      pending_reqs.push_back(mk_frame(29'h1FFF_FFFF, 1'b1, 4'd9, 64'h8000_0000_0000_0001,
                                      32'd1));
      pending_reqs.push_back(mk_frame(29'h1FFF_FFFF, 1'b0, 4'd4, 64'hFFFF_0000_FFFF_0000,
                                      32'd2));
      pending_reqs.push_back(mk_frame(29'd0, 1'b0, 4'd1, 64'h5555_5555_5555_5555, 32'd3));
      pending_reqs.push_back(mk_frame(29'd0, 1'b0, 4'd2, 64'hAAAA_AAAA_AAAA_AAAA, 32'd4));
      pending_reqs.push_back(mk_read(7'd0));
      pending_reqs.push_back(mk_read(7'd1));
      pending_reqs.push_back(mk_read(7'd4));
      pending_reqs.push_back(mk_read(7'd5));
      pending_reqs.push_back(mk_read(7'd127));
      pending_reqs.push_back(mk_frame(29'h7FF, 1'b0, 4'd0, 64'd0, 32'hFFFF_FFFE));
      pending_reqs.push_back(mk_read(7'd2));
      gen_keys = '{'{1'b0, 29'd0}, '{1'b1, 29'd0}, '{1'b0, 29'h7FF},
                   '{1'b1, 29'h1FFF_FFFF}, '{1'b0, 29'h1FFF_FFFF}};

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            gen_used = (gen_keys.size() < TABLE_DEPTH) ? gen_keys.size() : TABLE_DEPTH;
            if (gen_used > 0 && $urandom_range(0, 4) != 0)
               idx = $urandom_range(0, gen_used - 1);
            else
               idx = $urandom_range(0, 127);
            item = mk_read(7'(idx));
         end else begin
            if ($urandom_range(0, 99) < 45) begin
               k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
            end else begin
               k.ext = 1'($urandom);
               k.id  = (!k.ext && $urandom_range(0, 4) != 0) ? 29'($urandom_range(0, 2047))
                                                             : 29'($urandom);
               known = 1'b0;
               foreach (gen_keys[j])
                  if (gen_keys[j] == k)
                     known = 1'b1;
               if (!known)
                  gen_keys.push_back(k);
            end
            len  = ($urandom_range(0, 9) == 9) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            item = mk_frame(k.id, k.ext, len, {$urandom, $urandom}, $urandom);
         end
         if ((i / 40) % 3 == 2)
            item.gap = 0;
         pending_reqs.push_back(item);
      end
      total_reqs = pending_reqs.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (reqs_taken_n < total_reqs)
         @(negedge clock);
      while (due_rsps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("can_id_survey_table_top_test: done, clean");
      else
         $display("can_id_survey_table_top_test: done, errors");
      $finish;
   end

endmodule
